FILE: rtl/mlk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlk_pkg: shared types and constants of the Morse letter keyer
// Element codes, register addresses, reset values and the letter pattern
// tables for a to z.
// ----------------------------------------------------------------------------
package mlk_pkg;

   localparam int TIME_W = 16;
   localparam int CHAR_W = 8;
   localparam int CNT_W  = 3;
   localparam int BITS_W = 4;

   typedef enum logic [1:0] {
      EL_INDICATOR = 2'd0,
      EL_DOT       = 2'd1,
      EL_DASH      = 2'd2
   } element_type;

   typedef enum logic [1:0] {
      REG_DOT       = 2'd0,
      REG_DASH      = 2'd1,
      REG_INDICATOR = 2'd2
   } reg_index_type;

   localparam logic [TIME_W-1:0] DOT_RESET       = 16'd250;
   localparam logic [TIME_W-1:0] DASH_RESET      = 16'd1000;
   localparam logic [TIME_W-1:0] INDICATOR_RESET = 16'd500;

   localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_Z = 8'h7a;

   // Element count per letter, and pattern bits with 1 for a dash; the
   // first element is the most significant used bit.
   localparam logic [CNT_W-1:0] SYM_COUNT [26] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
   };
   localparam logic [BITS_W-1:0] SYM_BITS [26] = '{
      4'd1, 4'd8, 4'd10, 4'd4, 4'd0, 4'd2, 4'd6, 4'd0, 4'd0, 4'd7, 4'd5, 4'd4, 4'd3,
      4'd2, 4'd7, 4'd6, 4'd13, 4'd2, 4'd0, 4'd1, 4'd1, 4'd1, 4'd3, 4'd9, 4'd11, 4'd12
   };

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [BITS_W-1:0] bits;
   } sym_type;

   function automatic sym_type letter_sym(input logic [CHAR_W-1:0] ch);
      sym_type           s;
      logic [CHAR_W-1:0] off;
      s   = '0;
      off = ch - CHAR_A;
      if (ch inside {[CHAR_A:CHAR_Z]}) begin
         s.count = SYM_COUNT[off[4:0]];
         s.bits  = SYM_BITS[off[4:0]];
      end
      return s;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/morse_letter_keyer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: the first element of a character passes through the intake
// register, the pattern queue and the registered output stage.
// Throughput: one element per cycle while the output is not stalled; a
// character gives the indicator and its dots and dashes, one to five in all.
// Reset: synchronous; empties the queue and output stage and restores the
// dot, dash and indicator times to 250, 1000 and 500.
// ----------------------------------------------------------------------------
// morse_letter_keyer_unit: Morse letter keyer
// Turns each character into an indicator pulse followed by the timed dots
// and dashes of a to z letters, with the element times set over the CSR port.
// ----------------------------------------------------------------------------
module morse_letter_keyer_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] letter
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [1:0] element, [17:2] high_time_ms,
                                         // [33:18] low_time_ms, [39:34] zero
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import mlk_pkg::*;

   logic [TIME_W-1:0] dot_ff, dot_in;
   logic [TIME_W-1:0] dash_ff, dash_in;
   logic [TIME_W-1:0] ind_ff, ind_in;
   logic              wr_en;
   reg_index_type     reg_sel;

   logic    push_valid, push_ready;
   sym_type push_sym;
   logic    head_valid, pop;
   sym_type head_sym;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      dot_in  = dot_ff;
      dash_in = dash_ff;
      ind_in  = ind_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_DOT:       dot_in  = csr_pwdata[TIME_W-1:0];
            REG_DASH:      dash_in = csr_pwdata[TIME_W-1:0];
            REG_INDICATOR: ind_in  = csr_pwdata[TIME_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DOT:       csr_prdata = {16'd0, dot_ff};
         REG_DASH:      csr_prdata = {16'd0, dash_ff};
         REG_INDICATOR: csr_prdata = {16'd0, ind_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff  <= DOT_RESET;
         dash_ff <= DASH_RESET;
         ind_ff  <= INDICATOR_RESET;
      end else begin
         dot_ff  <= dot_in;
         dash_ff <= dash_in;
         ind_ff  <= ind_in;
      end
   end

   mlk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_sym   (push_sym)
   );

   mlk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_sym   (push_sym),
      .head_valid (head_valid),
      .pop        (pop),
      .head_sym   (head_sym)
   );

   mlk_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_sym       (head_sym),
      .pop            (pop),
      .dot_time       (dot_ff),
      .dash_time      (dash_ff),
      .indicator_time (ind_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: rtl/mlk_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlk_front: character intake
// Accepts one character per cycle while the queue is not full and registers
// its Morse pattern for the queue.
// ----------------------------------------------------------------------------
module mlk_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [7:0]              req_tdata,
   output logic                         push_valid,
   input  wire logic                    push_ready,
   output mlk_pkg::sym_type             push_sym
);
   import mlk_pkg::*;

   logic    valid_ff, valid_in;
   sym_type sym_ff, sym_in;

   assign req_tready = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_sym   = sym_ff;

   always_comb begin
      valid_in = valid_ff;
      sym_in   = sym_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         sym_in   = letter_sym(req_tdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      sym_ff <= sym_in;
   end

endmodule
`default_nettype wire

FILE: rtl/mlk_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlk_queue: pattern queue
// Short first-in first-out queue between intake and element sequencer.
// ----------------------------------------------------------------------------
module mlk_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_valid,
   output logic                         push_ready,
   input  wire mlk_pkg::sym_type        push_sym,
   output logic                         head_valid,
   input  wire logic                    pop,
   output mlk_pkg::sym_type             head_sym
);
   import mlk_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(DEPTH);

   sym_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             do_push, do_pop;

   assign push_ready = (level_ff != FULL_LVL);
   assign head_valid = (level_ff != '0);
   assign head_sym   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_sym;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/mlk_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlk_back: element sequencer
// Walks the queued pattern into a registered output stage, one element per
// cycle unless stalled: the indicator pulse first, then each dot or dash.
// ----------------------------------------------------------------------------
module mlk_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  wire mlk_pkg::sym_type        head_sym,
   output logic                         pop,
   input  wire logic [15:0]             dot_time,
   input  wire logic [15:0]             dash_time,
   input  wire logic [15:0]             indicator_time,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [39:0]                  rsp_tdata,
   output logic                         rsp_tlast
);
   import mlk_pkg::*;

   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              valid_ff, valid_in;
   element_type       el_ff, el_in;
   logic [TIME_W-1:0] hi_ff, hi_in;
   logic [TIME_W-1:0] lo_ff, lo_in;
   logic              last_ff, last_in;
   logic              load;
   logic [CNT_W-1:0]  shift;
   logic              is_dash;
   logic [TIME_W-1:0] t;

   assign load    = head_valid && (!valid_ff || rsp_tready);
   assign shift   = head_sym.count - idx_ff;
   assign is_dash = head_sym.bits[shift[1:0]];
   assign t       = is_dash ? dash_time : dot_time;

   always_comb begin
      el_in   = el_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      last_in = last_ff;
      idx_in  = idx_ff;
      pop     = 1'b0;
      valid_in = valid_ff && !rsp_tready;
      if (load) begin
         valid_in = 1'b1;
         if (idx_ff == '0) begin
            el_in   = EL_INDICATOR;
            hi_in   = indicator_time;
            lo_in   = '0;
            last_in = (head_sym.count == '0);
         end else begin
            el_in   = is_dash ? EL_DASH : EL_DOT;
            hi_in   = t;
            lo_in   = t;
            last_in = (idx_ff == head_sym.count);
         end
         if (last_in) begin
            pop    = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      el_ff   <= el_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {6'd0, lo_ff, hi_ff, el_ff};

endmodule
`default_nettype wire

FILE: tb/sv/mlk_element_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlk_element_checker: element predictor and comparator for the keyer
// Follows the timing registers through the CSR port, turns every accepted
// letter into its indicator pulse and Morse elements, and compares each
// accepted output element with the oldest one still waiting.
// ----------------------------------------------------------------------------
module mlk_element_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] letter
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,   // [1:0] element, [17:2] high_time_ms,
                                         // [33:18] low_time_ms, [39:34] zero
   input  wire logic        rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               mismatch_count,
   output int               elements_waiting,
   output int               elements_checked
);
   import mlk_pkg::*;

   typedef struct packed {
      element_type       kind;
      logic [TIME_W-1:0] high_ms;
      logic [TIME_W-1:0] low_ms;
      logic              last;
   } keyed_element_type;

   keyed_element_type expected_elements [$];
   keyed_element_type oldest;
   logic [TIME_W-1:0] dot_ms       = DOT_RESET;
   logic [TIME_W-1:0] dash_ms      = DASH_RESET;
   logic [TIME_W-1:0] indicator_ms = INDICATOR_RESET;
   int                mismatches   = 0;
   int                checked      = 0;

   function automatic string morse_code(input logic [7:0] ch);
      case (ch)
         "a": return ".-";
         "b": return "-...";
         "c": return "-.-.";
         "d": return "-..";
         "e": return ".";
         "f": return "..-.";
         "g": return "--.";
         "h": return "....";
         "i": return "..";
         "j": return ".---";
         "k": return "-.-";
         "l": return ".-..";
         "m": return "--";
         "n": return "-.";
         "o": return "---";
         "p": return ".--.";
         "q": return "--.-";
         "r": return ".-.";
         "s": return "...";
         "t": return "-";
         "u": return "..-";
         "v": return "...-";
         "w": return ".--";
         "x": return "-..-";
         "y": return "-.--";
         "z": return "--..";
         default: return "";
      endcase
   endfunction

   task automatic predict_elements(input logic [7:0] ch);
      string             code;
      keyed_element_type item;
      int                i;
      code         = morse_code(ch);
      item.kind    = EL_INDICATOR;
      item.high_ms = indicator_ms;
      item.low_ms  = '0;
      item.last    = (code.len() == 0);
      expected_elements.push_back(item);
      for (i = 0; i < code.len(); i++) begin
         if (code[i] == "-") begin
            item.kind    = EL_DASH;
            item.high_ms = dash_ms;
         end else begin
            item.kind    = EL_DOT;
            item.high_ms = dot_ms;
         end
         item.low_ms = item.high_ms;
         item.last   = (i == code.len() - 1);
         expected_elements.push_back(item);
      end
   endtask

   task automatic report_mismatch(input string detail);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch at %0t ns: %s", $time, detail);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_elements.delete();
         dot_ms       <= DOT_RESET;
         dash_ms      <= DASH_RESET;
         indicator_ms <= INDICATOR_RESET;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[1:0] == 2'b00) begin
            case (csr_paddr[3:2])
               REG_DOT:       dot_ms       <= csr_pwdata[TIME_W-1:0];
               REG_DASH:      dash_ms      <= csr_pwdata[TIME_W-1:0];
               REG_INDICATOR: indicator_ms <= csr_pwdata[TIME_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_elements(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (expected_elements.size() == 0) begin
               report_mismatch($sformatf("unexpected element %h last %b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               oldest = expected_elements.pop_front();
               if (rsp_tdata[1:0] !== oldest.kind || rsp_tdata[17:2] !== oldest.high_ms ||
                   rsp_tdata[33:18] !== oldest.low_ms || rsp_tlast !== oldest.last ||
                   rsp_tdata[39:34] !== 6'd0) begin
                  report_mismatch($sformatf(
                     {"expected kind %0d high %0d low %0d last %0d, ",
                      "got kind %0d high %0d low %0d last %0d pad %h"},
                     oldest.kind, oldest.high_ms, oldest.low_ms, oldest.last,
                     rsp_tdata[1:0], rsp_tdata[17:2], rsp_tdata[33:18], rsp_tlast,
                     rsp_tdata[39:34]));
               end
            end
         end
      end
      mismatch_count   <= mismatches;
      elements_waiting <= expected_elements.size();
      elements_checked <= checked;
   end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the Morse letter keyer
// Sends directed and random characters in bursts under several timing
// register settings, stalls the element output on its own pattern and
// once for a long stretch, and reports the verdict of the element checker.
// ----------------------------------------------------------------------------
module tb;
   import mlk_pkg::*;

   localparam int         WATCHDOG_LIMIT   = 2000;
   localparam int         SETTLE_CYCLES    = 12;
   localparam int         LONG_HOLD_CYCLES = 200;
   localparam int         PHASE_COUNT      = 7;
   localparam int         LETTERS_PER_PHASE = 28;
   localparam logic [3:0] ADDR_DOT         = {REG_DOT, 2'b00};
   localparam logic [3:0] ADDR_DASH        = {REG_DASH, 2'b00};
   localparam logic [3:0] ADDR_INDICATOR   = {REG_INDICATOR, 2'b00};
   localparam logic [3:0] ADDR_UNUSED      = 4'hC;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = 4'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int   mismatch_count;
   int   elements_waiting;
   int   elements_checked;

   int   letters_sent  = 0;
   int   reg_writes    = 0;
   int   burst_left    = 0;
   bit   no_gaps       = 1'b0;
   logic long_hold_req = 1'b0;
   int   quiet_cycles  = 0;

   int   hold_left      = 0;
   bit   long_hold_done = 1'b0;
   int   stall_mode     = 0;
   int   mode_left      = 0;
   int   stall_tick     = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   morse_letter_keyer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mlk_element_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .mismatch_count   (mismatch_count),
      .elements_waiting (elements_waiting),
      .elements_checked (elements_checked)
   );

   // The output side stalls on a mix of patterns, and once for a long stretch
   // so that the block fills up and holds off new characters.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (long_hold_req && !long_hold_done) begin
            hold_left      = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(8, 60);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 2) == 0);
               default: rsp_tready <= stall_tick[2];
            endcase
            stall_tick++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_letter(input logic [7:0] ch);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      letters_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (no_gaps || $urandom_range(0, 3) == 0) begin
            gap = 0;
         end else begin
            gap = $urandom_range(1, 15);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_for_elements();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (elements_waiting != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   task automatic set_timing(input logic [31:0] dot, input logic [31:0] dash,
                             input logic [31:0] indicator);
      write_reg(ADDR_DOT, dot);
      write_reg(ADDR_DASH, dash);
      write_reg(ADDR_INDICATOR, indicator);
   endtask

   initial begin
      logic [7:0] directed [$];
      int         p;
      int         n;
      directed = '{8'h00, 8'hFF, 8'h60, 8'h7B, "A", "Z", "0", "9", " ",
                   "a", "z", "e", "t", "h", "o", "q", "y", "b", "c", "j"};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset timing first, with characters outside a to z among the letters.
      foreach (directed[i]) send_letter(directed[i]);

      for (p = 0; p < PHASE_COUNT; p++) begin
         wait_for_elements();
         case (p)
            1: set_timing(32'd1, 32'd1, 32'd1);
            2: set_timing(32'hFFFF, 32'hFFFF, 32'hFFFF);
            3: begin
               set_timing($urandom_range(1, 65535), $urandom_range(1, 65535),
                          $urandom_range(1, 65535));
               write_reg(ADDR_UNUSED, $urandom);
            end
            4: set_timing({16'hFFFF, 16'($urandom_range(1, 65535))},
                          {16'h8001, 16'($urandom_range(1, 65535))},
                          {16'h5A5A, 16'($urandom_range(1, 65535))});
            5: set_timing(32'd0, 32'd0, 32'd0);
            6: set_timing($urandom_range(1, 65535), $urandom_range(1, 65535),
                          $urandom_range(1, 65535));
            default: ;
         endcase
         if (p == PHASE_COUNT - 1) begin
            no_gaps       = 1'b1;
            long_hold_req <= 1'b1;
         end
         for (n = 0; n < LETTERS_PER_PHASE; n++) begin
            if ($urandom_range(0, 4) != 0) begin
               send_letter(8'(CHAR_A + $urandom_range(0, 25)));
            end else begin
               send_letter(8'($urandom_range(0, 255)));
            end
         end
         no_gaps = 1'b0;
      end

      wait_for_elements();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d letters and %0d checked elements under seven timing settings,",
               letters_sent, elements_checked);
      $display("with %0d register writes including zero, wide and unmapped ones", reg_writes);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
